// ===== hdl/bmp_pkg.sv =====
`default_nettype none
package bmp_pkg;

  localparam int ROW_W = 64;
  localparam int IDX_W = 6;
  localparam int CNT_W = 7;

  typedef enum logic [1:0] {
    KIND_LOAD_A  = 2'd0,
    KIND_LOAD_B  = 2'd1,
    KIND_COMPUTE = 2'd2
  } kind_t;

  localparam logic REG_ROWS_USED  = 1'b0;
  localparam logic REG_INNER_USED = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_AROW,
    S_WALK,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    logic             clear;
    logic             load_arow;
    logic             step;
    logic [IDX_W-1:0] sel;
  } acc_ctrl_t;

  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v,
                                                    input logic [CNT_W-1:0] lim);
    return (v > lim) ? lim : v;
  endfunction

  function automatic logic [ROW_W-1:0] low_mask(input logic [CNT_W-1:0] n);
    logic [ROW_W-1:0] m;
    for (int j = 0; j < ROW_W; j++) begin
      m[j] = (CNT_W'(j) < n);
    end
    return m;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/bmp_store.sv =====
`default_nettype none
module bmp_store #(
  parameter int DEPTH = 64
) (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [$clog2(DEPTH)-1:0]     waddr,
  input  wire logic [bmp_pkg::ROW_W-1:0]    wdata,
  input  wire logic [$clog2(DEPTH)-1:0]     raddr,
  output logic      [bmp_pkg::ROW_W-1:0]    rdata
);
  import bmp_pkg::*;

  logic [ROW_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/bmp_acc.sv =====
`default_nettype none
module bmp_acc #(
  parameter int SIZE = 64
) (
  input  wire logic                       clk,
  input  wire bmp_pkg::acc_ctrl_t         ctrl,
  input  wire logic [bmp_pkg::CNT_W-1:0]  rows_used,
  input  wire logic [bmp_pkg::ROW_W-1:0]  a_rdata,
  input  wire logic [bmp_pkg::ROW_W-1:0]  b_rdata,
  output logic      [bmp_pkg::ROW_W-1:0]  product_bits
);
  import bmp_pkg::*;

  localparam logic [CNT_W-1:0] SIZE_CNT = CNT_W'(SIZE);

  logic [ROW_W-1:0] arow_r, arow_nxt;
  logic [ROW_W-1:0] acc_r, acc_nxt;
  logic [ROW_W-1:0] mask_r, mask_nxt;

  always_comb begin
    arow_nxt = arow_r;
    acc_nxt  = acc_r;
    mask_nxt = mask_r;
    if (ctrl.clear) begin
      acc_nxt  = '0;
      mask_nxt = low_mask(clamp_count(rows_used, SIZE_CNT));
    end
    if (ctrl.load_arow) begin
      arow_nxt = a_rdata;
    end
    if (ctrl.step && arow_r[ctrl.sel]) begin
      acc_nxt = acc_r | b_rdata;
    end
  end

  always_ff @(posedge clk) begin
    arow_r <= arow_nxt;
    acc_r  <= acc_nxt;
    mask_r <= mask_nxt;
  end

  assign product_bits = acc_r & mask_r;

endmodule
`default_nettype wire

// ===== hdl/bmp_seq.sv =====
`default_nettype none
module bmp_seq #(
  parameter int SIZE = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [1:0]                 in_kind,
  input  wire logic [bmp_pkg::IDX_W-1:0]  in_index,
  input  wire logic [bmp_pkg::CNT_W-1:0]  inner_used,
  output logic                            busy,
  output logic                            out_valid,
  output logic [bmp_pkg::IDX_W-1:0]       out_result_row,
  output logic [$clog2(SIZE)-1:0]         b_raddr,
  output bmp_pkg::acc_ctrl_t              ctrl
);
  import bmp_pkg::*;

  localparam int AW = $clog2(SIZE);
  localparam logic [CNT_W-1:0] SIZE_CNT = CNT_W'(SIZE);

  seq_state_t       state_r, state_nxt;
  logic [AW-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0] inner_r, inner_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] inner_clamp;
  logic             accept_cmp;
  logic             last;

  assign inner_clamp = clamp_count(inner_used, SIZE_CNT);
  assign accept_cmp  = start && (state_r == S_IDLE) && (in_kind == KIND_COMPUTE);
  assign last        = ((CNT_W'(cnt_r) + CNT_W'(1)) == inner_r);

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    inner_nxt      = inner_r;
    idx_nxt        = idx_r;
    b_raddr        = '0;
    ctrl.clear     = 1'b0;
    ctrl.load_arow = 1'b0;
    ctrl.step      = 1'b0;
    ctrl.sel       = IDX_W'(cnt_r);
    busy           = (state_r != S_IDLE);
    out_valid      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept_cmp) begin
          ctrl.clear = 1'b1;
          idx_nxt    = in_index;
          inner_nxt  = inner_clamp;
          if ((CNT_W'(in_index) < SIZE_CNT) && (inner_clamp != '0)) begin
            state_nxt = S_AROW;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_AROW: begin
        ctrl.load_arow = 1'b1;
        b_raddr        = '0;
        cnt_nxt        = '0;
        state_nxt      = S_WALK;
      end
      S_WALK: begin
        ctrl.step = 1'b1;
        b_raddr   = cnt_r + AW'(1);
        if (last) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end
      S_DONE: begin
        out_valid = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    inner_r <= inner_nxt;
    idx_r   <= idx_nxt;
  end

  assign out_result_row = idx_r;

`ifndef ASSERT_OFF
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_busy_ends_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> $past(out_valid))
    else $error("busy dropped without a result");

  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> ((CNT_W'(cnt_r) < inner_r) && (inner_r <= SIZE_CNT)))
    else $error("inner walk past inner size");

  a_compute_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept_cmp |=> busy)
    else $error("compute transfer did not start work");
`endif

endmodule
`default_nettype wire

// ===== hdl/boolean_matrix_product.sv =====
// compute item: after the accepting edge the sequencer runs S_AROW, S_WALK and S_DONE in turn
//   (an A row read, a walk over the inner rows through the single B read port, a result strobe)
// a new item is taken only once busy falls; an index >= SIZE or inner 0 goes straight to the result
// load items: taken whenever not busy, back to back; the receiver cannot stall, the strobe lasts one cycle
// synchronous active-low reset returns to idle, rows_used and inner_used to 64;
// matrix stores are not cleared
`default_nettype none
module boolean_matrix_product #(
  parameter int SIZE = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [1:0]                 in_kind,
  input  wire logic [bmp_pkg::IDX_W-1:0]  in_index,
  input  wire logic [bmp_pkg::ROW_W-1:0]  in_row_bits,
  output logic                            out_valid,
  output logic [bmp_pkg::IDX_W-1:0]       out_result_row,
  output logic [bmp_pkg::ROW_W-1:0]       out_product_bits,
  input  wire logic                       cfg_we,
  input  wire logic                       cfg_index,
  input  wire logic [bmp_pkg::CNT_W-1:0]  cfg_wdata
);
  import bmp_pkg::*;

  localparam int AW = $clog2(SIZE);
  localparam logic [CNT_W-1:0] SIZE_CNT = CNT_W'(SIZE);

  logic [CNT_W-1:0] rows_used_r, rows_used_nxt;
  logic [CNT_W-1:0] inner_used_r, inner_used_nxt;
  logic             in_xfer;
  logic             idx_ok;
  logic             a_we, b_we;
  logic [ROW_W-1:0] a_rdata, b_rdata;
  logic [AW-1:0]    b_raddr;
  acc_ctrl_t        ctrl;

  assign in_xfer = start && !busy;
  assign idx_ok  = (CNT_W'(in_index) < SIZE_CNT);
  assign a_we    = in_xfer && idx_ok && (in_kind == KIND_LOAD_A);
  assign b_we    = in_xfer && idx_ok && (in_kind == KIND_LOAD_B);

  always_comb begin
    rows_used_nxt  = rows_used_r;
    inner_used_nxt = inner_used_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_ROWS_USED:  rows_used_nxt  = cfg_wdata;
        REG_INNER_USED: inner_used_nxt = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_used_r  <= 7'd64;
      inner_used_r <= 7'd64;
    end else begin
      rows_used_r  <= rows_used_nxt;
      inner_used_r <= inner_used_nxt;
    end
  end

  bmp_store #(.DEPTH(SIZE)) u_a_store (
    .clk   (clk),
    .we    (a_we),
    .waddr (in_index[AW-1:0]),
    .wdata (in_row_bits),
    .raddr (in_index[AW-1:0]),
    .rdata (a_rdata)
  );

  bmp_store #(.DEPTH(SIZE)) u_b_store (
    .clk   (clk),
    .we    (b_we),
    .waddr (in_index[AW-1:0]),
    .wdata (in_row_bits),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  bmp_seq #(.SIZE(SIZE)) u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .in_kind        (in_kind),
    .in_index       (in_index),
    .inner_used     (inner_used_r),
    .busy           (busy),
    .out_valid      (out_valid),
    .out_result_row (out_result_row),
    .b_raddr        (b_raddr),
    .ctrl           (ctrl)
  );

  bmp_acc #(.SIZE(SIZE)) u_acc (
    .clk          (clk),
    .ctrl         (ctrl),
    .rows_used    (rows_used_r),
    .a_rdata      (a_rdata),
    .b_rdata      (b_rdata),
    .product_bits (out_product_bits)
  );

endmodule
`default_nettype wire

// ===== verif/boolean_matrix_product_tb.sv =====
module boolean_matrix_product_tb;
  import bmp_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 70;

  class product_checker;
    logic [ROW_W-1:0] a_rows [64];
    logic [ROW_W-1:0] b_rows [64];
    logic [CNT_W-1:0] rows_used = 7'd64;
    logic [CNT_W-1:0] inner_used = 7'd64;
    logic [IDX_W-1:0] outstanding_rows [$];
    logic [ROW_W-1:0] outstanding_bits [$];
    int mismatches = 0;
    int checked = 0;

    function void write_register(logic which, logic [CNT_W-1:0] value);
      if (which == REG_ROWS_USED) begin
        rows_used = value;
      end else begin
        inner_used = value;
      end
    endfunction

    function int effective_inner();
      return (inner_used > 64) ? 64 : int'(inner_used);
    endfunction

    function logic [ROW_W-1:0] product_row(logic [IDX_W-1:0] r);
      logic [ROW_W-1:0] acc;
      logic [ROW_W-1:0] keep;
      int i;
      acc = '0;
      for (i = 0; i < effective_inner(); i++) begin
        if (a_rows[r][i]) begin
          acc |= b_rows[i];
        end
      end
      keep = (rows_used >= 64) ? '1 : ((64'd1 << rows_used) - 64'd1);
      return acc & keep;
    endfunction

    function void note_transfer(logic [1:0] k, logic [IDX_W-1:0] idx,
                                logic [ROW_W-1:0] bits);
      case (k)
        KIND_LOAD_A: a_rows[idx] = bits;
        KIND_LOAD_B: b_rows[idx] = bits;
        KIND_COMPUTE: begin
          outstanding_rows.push_back(idx);
          outstanding_bits.push_back(product_row(idx));
        end
        default: ;
      endcase
    endfunction

    function void flag(string what, logic [ROW_W-1:0] want, logic [ROW_W-1:0] got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch on %s: expected %h, got %h", what, want, got);
      end
    endfunction

    function void check_result(logic [IDX_W-1:0] row, logic [ROW_W-1:0] bits);
      logic [IDX_W-1:0] want_row;
      logic [ROW_W-1:0] want_bits;
      checked++;
      if (outstanding_rows.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("product row %0d arrived with nothing outstanding", row);
        end
        return;
      end
      want_row = outstanding_rows.pop_front();
      want_bits = outstanding_bits.pop_front();
      if (row !== want_row) begin
        flag("result_row", ROW_W'(want_row), ROW_W'(row));
      end
      if (bits !== want_bits) begin
        flag($sformatf("product_bits of row %0d", want_row), want_bits, bits);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [1:0]          in_kind;
  logic [IDX_W-1:0]    in_index;
  logic [ROW_W-1:0]    in_row_bits;
  logic                out_valid;
  logic [IDX_W-1:0]    out_result_row;
  logic [ROW_W-1:0]    out_product_bits;
  logic                cfg_we;
  logic                cfg_index;
  logic [CNT_W-1:0]    cfg_wdata;

  product_checker products;
  bit a_loaded [64];
  bit b_loaded [64];
  int idle_pct;
  int unsigned cycles = 0;
  int n_loads;
  int n_computes;
  int n_ignored;
  int n_settings;

  boolean_matrix_product dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_index         (in_index),
    .in_row_bits      (in_row_bits),
    .out_valid        (out_valid),
    .out_result_row   (out_result_row),
    .out_product_bits (out_product_bits),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      products.check_result(out_result_row, out_product_bits);
    end
  end

  function automatic int pick_gap();
    int g;
    g = 0;
    while (g < 200 && $urandom_range(99) < idle_pct) begin
      g++;
    end
    return g;
  endfunction

  function automatic logic [ROW_W-1:0] pick_bits();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return 64'd1 << $urandom_range(63);
      3: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic transfer_item(input logic [1:0] k, input logic [IDX_W-1:0] idx,
                               input logic [ROW_W-1:0] bits);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_kind <= k;
    in_index <= idx;
    in_row_bits <= bits;
    do @(posedge clk); while (busy);
    products.note_transfer(k, idx, bits);
    case (k)
      KIND_LOAD_A: begin
        a_loaded[idx] = 1'b1;
        n_loads++;
      end
      KIND_LOAD_B: begin
        b_loaded[idx] = 1'b1;
        n_loads++;
      end
      KIND_COMPUTE: n_computes++;
      default: n_ignored++;
    endcase
  endtask

  task automatic settle();
    start <= 1'b0;
    while (products.outstanding_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_counts(input logic [CNT_W-1:0] rows, input logic [CNT_W-1:0] inner);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= REG_ROWS_USED;
    cfg_wdata <= rows;
    @(posedge clk);
    products.write_register(REG_ROWS_USED, rows);
    cfg_index <= REG_INNER_USED;
    cfg_wdata <= inner;
    @(posedge clk);
    products.write_register(REG_INNER_USED, inner);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // compute requests only go out once the A row and every B row it selects are loaded
  task automatic random_item();
    logic [IDX_W-1:0] r;
    int roll;
    int miss;
    int i;
    roll = $urandom_range(99);
    r = IDX_W'($urandom_range(63));
    if (roll < 30) begin
      transfer_item(KIND_LOAD_A, r, pick_bits());
    end else if (roll < 55) begin
      transfer_item(KIND_LOAD_B, r, pick_bits());
    end else if (!a_loaded[r]) begin
      transfer_item(KIND_LOAD_A, r, pick_bits());
    end else begin
      miss = -1;
      for (i = 0; i < products.effective_inner(); i++) begin
        if (miss < 0 && products.a_rows[r][i] && !b_loaded[i]) begin
          miss = i;
        end
      end
      if (miss >= 0) begin
        transfer_item(KIND_LOAD_B, IDX_W'(miss), pick_bits());
      end else begin
        transfer_item(KIND_COMPUTE, r, pick_bits());
      end
    end
  endtask

  initial begin
    int p;
    int n;
    logic [CNT_W-1:0] rows;
    logic [CNT_W-1:0] inner;
    products = new();
    idle_pct = 0;
    start <= 1'b0;
    in_kind <= KIND_LOAD_A;
    in_index <= '0;
    in_row_bits <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_ROWS_USED;
    cfg_wdata <= '0;
    rst_n <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    transfer_item(KIND_LOAD_B, 6'd0, '1);
    transfer_item(KIND_LOAD_B, 6'd1, '0);
    transfer_item(KIND_LOAD_B, 6'd63, 64'h8000_0000_0000_0001);
    transfer_item(KIND_LOAD_A, 6'd0, 64'd1);
    transfer_item(KIND_LOAD_A, 6'd63, 64'h8000_0000_0000_0000);
    transfer_item(KIND_LOAD_A, 6'd1, '0);
    transfer_item(KIND_LOAD_A, 6'd2, 64'h8000_0000_0000_0003);
    transfer_item(KIND_COMPUTE, 6'd0, '1);
    transfer_item(KIND_COMPUTE, 6'd63, '0);
    transfer_item(KIND_COMPUTE, 6'd1, 64'h5555_aaaa_5555_aaaa);
    transfer_item(KIND_COMPUTE, 6'd2, '0);
    // unused kind must neither answer nor overwrite A row 0
    transfer_item(KIND_UNUSED, 6'd0, '0);
    transfer_item(KIND_COMPUTE, 6'd0, '0);
    write_counts(7'd0, 7'd64);
    transfer_item(KIND_COMPUTE, 6'd2, '0);
    write_counts(7'd64, 7'd0);
    transfer_item(KIND_COMPUTE, 6'd0, '0);
    write_counts(7'd127, 7'd127);
    transfer_item(KIND_COMPUTE, 6'd2, '0);
    write_counts(7'd3, 7'd64);
    transfer_item(KIND_COMPUTE, 6'd63, '0);
    write_counts(7'd64, 7'd1);
    transfer_item(KIND_COMPUTE, 6'd2, '0);
    transfer_item(KIND_COMPUTE, 6'd63, '0);

    for (p = 0; p < 9; p++) begin
      case (p)
        0: begin
          rows = 7'd64;
          inner = 7'd64;
        end
        1: begin
          rows = 7'd1;
          inner = 7'd1;
        end
        2: begin
          rows = 7'd64;
          inner = 7'd1;
        end
        3: begin
          rows = 7'd1;
          inner = 7'd64;
        end
        4: begin
          rows = 7'd0;
          inner = 7'd17;
        end
        5: begin
          rows = 7'd23;
          inner = 7'd0;
        end
        6: begin
          rows = 7'd127;
          inner = 7'd65;
        end
        default: begin
          rows = CNT_W'($urandom_range(1, 64));
          inner = CNT_W'($urandom_range(1, 64));
        end
      endcase
      write_counts(rows, inner);
      idle_pct = (p % 4 == 1) ? 85 : ((p % 4 == 3) ? 7 : 0);
      for (n = 0; n < 80; n++) begin
        if ($urandom_range(19) == 0) begin
          transfer_item(KIND_UNUSED, IDX_W'($urandom_range(63)), pick_bits());
        end
        random_item();
      end
    end

    settle();
    $display("covered %0d row loads and %0d product rows over %0d register settings",
             n_loads, n_computes, n_settings + 1);
    $display("%0d product rows checked, %0d unused-kind transfers ignored",
             products.checked, n_ignored);
    if (products.mismatches == 0 && products.outstanding_rows.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== boolean_matrix_product.f =====
hdl/bmp_pkg.sv
hdl/bmp_store.sv
hdl/bmp_acc.sv
hdl/bmp_seq.sv
hdl/boolean_matrix_product.sv
verif/boolean_matrix_product_tb.sv
